// ===== rtl/core/route_graph_min_transfers_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Route graph minimum transfers: assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROUTE_GRAPH_MIN_TRANSFERS_UNIT_MACROS_SVH
`define ROUTE_GRAPH_MIN_TRANSFERS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RGMT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rgmt assertion failed");
`define RGMT_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rgmt forbidden condition");
`else
`define RGMT_ASSERT(lbl, prop)
`define RGMT_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/rgmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Route graph minimum transfers: package
// Request and response types, field widths, codes and sequencer states.
// ----------------------------------------------------------------------------
package rgmt_pkg;

	localparam int STATION_W        = 9;
	localparam int WORD_W           = 64;
	localparam int MAX_STATIONS_DEF = 512;
	localparam logic [STATION_W-1:0] COUNT_RESET = 9'd511;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [STATION_W-1:0] station;
		logic                 route_end;
	} req_t;

	typedef struct packed {
		logic                 reachable;
		logic [STATION_W-1:0] transfers;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_SINIT,
		S_SCAN,
		S_LEVEL,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/rgmt_edge_ram.sv =====
// ----------------------------------------------------------------------------
// Route graph minimum transfers: edge memory
// Word-wide adjacency store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rgmt_edge_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rgmt_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [rgmt_pkg::WORD_W-1:0] rdata
);
	import rgmt_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rgmt_bfs_core.sv =====
// ----------------------------------------------------------------------------
// Route graph minimum transfers: sequencer and search datapath
// Clears the edge memory, merges route members into station rows and runs a
// level-by-level search that ANDs each row word with the frontier word.
// ----------------------------------------------------------------------------
module rgmt_bfs_core #(
	parameter int MAX_STATIONS = rgmt_pkg::MAX_STATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  rgmt_pkg::req_t                 req,
	input  logic [rgmt_pkg::STATION_W-1:0] station_count,
	output logic                           res_valid,
	input  logic                           res_ready,
	output rgmt_pkg::rsp_t                 res
);
	import rgmt_pkg::*;

`include "route_graph_min_transfers_unit_macros.svh"

	localparam int ROW_WORDS = (MAX_STATIONS + WORD_W - 1) / WORD_W;
	localparam int DEPTH     = MAX_STATIONS * ROW_WORDS;
	localparam int AW        = $clog2(DEPTH);
	localparam int VW        = $clog2(MAX_STATIONS);
	localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int CW        = $clog2(ROW_WORDS + 1);
	localparam int SETW      = ROW_WORDS * WORD_W;

	state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	logic [VW-1:0]     st_q, tgt_q, v_q, v_s1, level_q;
	logic              last_q;
	logic [CW-1:0]     k_q;
	logic [WW-1:0]     w_q, w_s1, kw_m1;
	logic              issue_q, vld_s1, acc_q, any_q;
	logic [SETW-1:0]   visited_q, frontier_q, next_q, members_q;
	rsp_t              res_q;

	logic              accept, in_range, lastw_q, lastw_s1, lastv_s1, hit, found;
	logic [VW-1:0]     tgt_in;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	function automatic logic [AW-1:0] mk_addr(input logic [VW-1:0] v, input logic [WW-1:0] w);
		return AW'(32'(v) * ROW_WORDS + 32'(w));
	endfunction

	rgmt_edge_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept   = req_valid && !req_stall;
	assign in_range = 32'(req.station) < MAX_STATIONS;
	assign tgt_in   = (32'(station_count) >= MAX_STATIONS) ? VW'(MAX_STATIONS - 1)
		: VW'(station_count);
	assign lastw_q  = w_q == WW'(ROW_WORDS - 1);
	assign lastw_s1 = w_s1 == WW'(ROW_WORDS - 1);
	assign lastv_s1 = v_s1 == tgt_q;
	assign kw_m1    = WW'(k_q - CW'(1));
	assign hit      = |(rdata & frontier_q[32'(w_s1) * WORD_W +: WORD_W]);
	assign found    = (acc_q || hit) && !visited_q[v_s1];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (req.func == FUNC_SEARCH) state_d = S_SINIT;
					else if (in_range) state_d = S_ADD;
				end
			end
			S_ADD: begin
				if (k_q == CW'(ROW_WORDS)) state_d = S_IDLE;
			end
			S_SINIT: begin
				if (tgt_q == VW'(0) || tgt_q == VW'(1)) state_d = S_DONE;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (vld_s1 && lastw_s1 && lastv_s1) state_d = S_LEVEL;
			end
			S_LEVEL: begin
				if (visited_q[tgt_q] || !any_q) state_d = S_DONE;
				else state_d = S_SCAN;
			end
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		req_stall = state_q != S_IDLE;
		res_valid = state_q == S_DONE;
		res       = res_q;
		we        = 1'b0;
		waddr     = clr_q;
		wdata     = '0;
		raddr     = mk_addr(st_q, k_q[WW-1:0]);
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_ADD: begin
				we    = k_q != '0;
				waddr = mk_addr(st_q, kw_m1);
				wdata = rdata | members_q[32'(kw_m1) * WORD_W +: WORD_W];
			end
			S_SCAN: begin
				raddr = mk_addr(v_q, w_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			k_q       <= '0;
			v_q       <= '0;
			w_q       <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			acc_q     <= 1'b0;
			any_q     <= 1'b0;
			level_q   <= '0;
			members_q <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN) && issue_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					k_q <= '0;
				end
				S_ADD: begin
					k_q <= k_q + CW'(1);
					if (k_q == CW'(ROW_WORDS)) begin
						if (last_q) members_q <= '0;
						else members_q[st_q] <= 1'b1;
					end
				end
				S_SINIT: begin
					level_q <= '0;
					any_q   <= 1'b0;
					acc_q   <= 1'b0;
					v_q     <= VW'(1);
					w_q     <= '0;
					issue_q <= tgt_q > VW'(1);
				end
				S_SCAN: begin
					if (issue_q) begin
						w_q <= lastw_q ? '0 : w_q + WW'(1);
						if (lastw_q) begin
							v_q <= v_q + VW'(1);
							if (v_q == tgt_q) issue_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						acc_q <= lastw_s1 ? 1'b0 : (acc_q || hit);
						if (lastw_s1 && found) any_q <= 1'b1;
					end
				end
				S_LEVEL: begin
					if (!visited_q[tgt_q] && any_q) begin
						level_q <= level_q + VW'(1);
						v_q     <= VW'(1);
						w_q     <= '0;
						issue_q <= 1'b1;
						any_q   <= 1'b0;
					end
				end
				default: begin
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		w_s1 <= w_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_q   <= VW'(req.station);
					last_q <= req.route_end;
					tgt_q  <= tgt_in;
				end
			end
			S_SINIT: begin
				visited_q    <= '0;
				visited_q[1] <= 1'b1;
				frontier_q    <= '0;
				frontier_q[1] <= 1'b1;
				next_q       <= '0;
				res_q.reachable <= tgt_q == VW'(1);
				res_q.transfers <= '0;
			end
			S_SCAN: begin
				if (vld_s1 && lastw_s1 && found) begin
					visited_q[v_s1] <= 1'b1;
					next_q[v_s1]    <= 1'b1;
				end
			end
			S_LEVEL: begin
				if (visited_q[tgt_q]) begin
					res_q.reachable <= 1'b1;
					res_q.transfers <= STATION_W'(level_q);
				end else if (!any_q) begin
					res_q.reachable <= 1'b0;
					res_q.transfers <= '0;
				end else begin
					frontier_q <= next_q;
					next_q     <= '0;
				end
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	`RGMT_ASSERT_NEVER(a_s1_only_in_scan, vld_s1 && (state_q != S_SCAN))
	`RGMT_ASSERT(a_level_drained, (state_q == S_LEVEL) |-> (!issue_q && !vld_s1))
	`RGMT_ASSERT(a_unreach_zero, (res_valid && !res.reachable) |-> (res.transfers == '0))
	`RGMT_ASSERT_NEVER(a_scan_in_range, issue_q && (state_q == S_SCAN) && (v_q > tgt_q))

endmodule

// ===== rtl/core/route_graph_min_transfers_unit.sv =====
// ----------------------------------------------------------------------------
// Route graph minimum transfers: top level
// Fewest bus changes from station 1 to the configured last station.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_STATIONS * ceil(MAX_STATIONS/64) words
// of the edge memory (4096 at the default) to zero, and holds req_stall high
// meanwhile; configuration writes are taken at any time. A station request
// does one read-modify-write of each 64-bit row word, reading through the
// memory read port and writing back through the write port. A search request
// runs level by level: each level reads every row word of stations 1 to
// target once through the shared memory read port, then drains the last
// read and swaps the frontier. A target of 0 or 1 answers without a scan.
// One request is handled at a time; a finished response waits in an output
// register while the next request is taken.
module route_graph_min_transfers_unit #(
	parameter int MAX_STATIONS = rgmt_pkg::MAX_STATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  rgmt_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rgmt_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rgmt_pkg::STATION_W-1:0] cfg_data
);
	import rgmt_pkg::*;

	logic [STATION_W-1:0] count_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 res_valid, res_ready;
	rsp_t                 res;

	assign cfg_ready = 1'b1;
	assign res_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	rgmt_bfs_core #(
		.MAX_STATIONS(MAX_STATIONS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.station_count(count_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) count_q <= cfg_data;
			if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (res_valid && res_ready) rsp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) rsp_q <= res;
	end

endmodule

// ===== test/route_graph_min_transfers_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route graph minimum transfers: testbench
// Loads bus routes into the unit and runs searches at several target counts.
// Each search answer is compared with a local breadth-first search over a
// mirrored edge matrix. Sender gaps and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module route_graph_min_transfers_unit_tb;
	import rgmt_pkg::*;

	localparam int STATIONS = MAX_STATIONS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [STATION_W-1:0] cfg_data = '0;

	bit link_map [STATIONS][STATIONS];
	bit route_open [STATIONS];
	logic [STATION_W-1:0] target_count = COUNT_RESET;
	rsp_t answers_due [$];
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int requests_sent = 0;

	route_graph_min_transfers_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	function automatic void add_to_route(input int st, input bit last);
		for (int m = 0; m < STATIONS; m++)
			if (route_open[m])
				link_map[m][st] = 1'b1;
		route_open[st] = 1'b1;
		if (last)
			foreach (route_open[i])
				route_open[i] = 1'b0;
	endfunction

	function automatic rsp_t fewest_transfers();
		int target;
		int u;
		bit seen [STATIONS];
		int rides [STATIONS];
		int frontier [$];
		rsp_t r;
		target = (target_count >= STATIONS) ? STATIONS - 1 : int'(target_count);
		seen[1] = 1'b1;
		rides[1] = 0;
		frontier = {frontier, 1};
		while (frontier.size() > 0) begin
			u = frontier.pop_front();
			if (u == target)
				break;
			for (int v = 1; v <= target; v++)
				if (link_map[u][v] && !seen[v]) begin
					seen[v] = 1'b1;
					rides[v] = rides[u] + 1;
					frontier = {frontier, v};
				end
		end
		r = '0;
		if (target != 0 && seen[target]) begin
			r.reachable = 1'b1;
			r.transfers = STATION_W'((rides[target] > 0) ? rides[target] - 1 : 0);
		end
		return r;
	endfunction

	task automatic send_request(input logic fn, input int st, input bit last);
		req_t r;
		r.func = fn;
		r.station = STATION_W'(st);
		r.route_end = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (fn == FUNC_SEARCH)
			answers_due = {answers_due, fewest_transfers()};
		else if (st < STATIONS)
			add_to_route(st, last);
		requests_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		wait (answers_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		cfg_data <= STATION_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		target_count = STATION_W'(value);
	endtask

	task automatic test_directed();
		send_request(FUNC_SEARCH, 0, 1'b0);
		send_request(FUNC_ADD, 1, 1'b0);
		send_request(FUNC_ADD, 511, 1'b1);
		send_request(FUNC_SEARCH, 511, 1'b1);
		send_request(FUNC_ADD, 0, 1'b0);
		send_request(FUNC_ADD, 5, 1'b0);
		send_request(FUNC_SEARCH, 256, 1'b1);
		send_request(FUNC_ADD, 5, 1'b0);
		send_request(FUNC_ADD, 6, 1'b1);
		send_request(FUNC_ADD, 1, 1'b0);
		send_request(FUNC_ADD, 3, 1'b1);
		send_request(FUNC_ADD, 3, 1'b0);
		send_request(FUNC_ADD, 5, 1'b1);
		drain();
		write_count(6);
		send_request(FUNC_SEARCH, 0, 1'b0);
		drain();
		write_count(1);
		send_request(FUNC_SEARCH, 170, 1'b0);
		drain();
		write_count(0);
		send_request(FUNC_SEARCH, 85, 1'b1);
		drain();
		write_count(511);
		send_request(FUNC_SEARCH, 0, 1'b0);
		drain();
	endtask

	task automatic test_random_routes();
		int count;
		int span;
		int len;
		bit big;
		while (requests_sent < 820) begin
			big = ($urandom_range(0, 9) == 0);
			count = big ? $urandom_range(0, 511) : $urandom_range(2, 40);
			write_count(count);
			span = (count + 2 > 511) ? 511 : count + 2;
			for (int k = 0; k < (big ? 3 : 10); k++) begin
				len = $urandom_range(1, 6);
				for (int j = 0; j < len; j++)
					send_request(FUNC_ADD,
						($urandom_range(0, 6) == 0) ? $urandom_range(0, 511)
							: $urandom_range(0, span),
						(j == len - 1) ? ($urandom_range(0, 6) != 0)
							: (($urandom_range(0, 1) == 1) && ($urandom_range(0, 7) == 0)));
				if (!big && $urandom_range(0, 2) == 0)
					send_request(FUNC_SEARCH, $urandom_range(0, 511),
						$urandom_range(0, 1) == 1);
			end
			send_request(FUNC_SEARCH, $urandom_range(0, 511), $urandom_range(0, 1) == 1);
			drain();
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case ((cycle_count / 200) % 4)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 1) == 0);
			2: rsp_stall <= ($urandom_range(0, 9) != 0);
			default: rsp_stall <= ((cycle_count % 7) < 3);
		endcase
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0)
				report_mismatch("unexpected response", 1, 0);
			else begin
				if (rsp.reachable !== answers_due[0].reachable)
					report_mismatch("reachable", int'(rsp.reachable),
						int'(answers_due[0].reachable));
				if (rsp.transfers !== answers_due[0].transfers)
					report_mismatch("transfers", int'(rsp.transfers),
						int'(answers_due[0].transfers));
				void'(answers_due.pop_front());
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_routes();
		drain();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rgmt_pkg.sv
rtl/core/rgmt_edge_ram.sv
rtl/core/rgmt_bfs_core.sv
rtl/core/route_graph_min_transfers_unit.sv
test/route_graph_min_transfers_unit_tb.sv
